// ===== hdl/bbr_pkg.sv =====
// shared constants and types for the 3x3 rgb box blur
// no dependencies; used by box_blur_3x3_rgb
package bbr_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 12;
	localparam int WCFG_W     = 12;
	localparam int HCFG_W     = 13;
	localparam int CFG_DATA_W = 13;
	localparam int PIX_W      = 24;
	localparam int SUM_W      = 12;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);

	// rounded divide by nine: floor((s + 4) * RECIP9 / 2^16) for s up to 9 * 255
	localparam int RECIP9    = 7282;
	localparam int RECIP9_W  = 13;
	localparam int RECIP_SH  = 16;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(640 - 1);
	localparam logic [ROW_W-1:0] HEIGHT_LAST_RST = ROW_W'(480 - 1);

endpackage

// ===== hdl/bbr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds while the read enable is low
module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/box_blur_3x3_rgb.sv =====
// 3x3 box blur over an rgb raster stream, two line buffers and a column window
// depends on bbr_pkg and bbr_ram
//
// channel   | dir | tdata (low bit first)                           | extra
// s_axis    | in  | red 8, green 8, blue 8                          | tuser frame_start
// m_axis    | out | row 12, col 11, red 8, green 8, blue 8, zero 1  | tlast last_in_burst
// cfg       | in  | cfg_index 0 frame_width, 1 frame_height         | cfg_we, cfg_data 13
//
// one pixel per cycle in unless the output stalls; results pass stage 1, stage 2
// and the output register. a pixel can cause two results (interior of the row
// above plus its own border value); both leave in turn while the input stalls.
// line buffer reads and writes share one column address per pixel; a write of the
// same column in flight is forwarded. reset clears counters, valids and configuration.
module box_blur_3x3_rgb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                          s_axis_tuser,  // frame_start
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata,  // out_row, out_col, red, green, blue, 0
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = bbr_pkg::COL_W;
	localparam int RW = bbr_pkg::ROW_W;
	localparam int SW = bbr_pkg::SUM_W;

	// configuration, kept as last column / last row after clamping
	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	logic [bbr_pkg::WCFG_W-1:0] cfg_w;
	logic [bbr_pkg::HCFG_W-1:0] cfg_h;

	assign cfg_w = cfg_data[bbr_pkg::WCFG_W-1:0];
	assign cfg_h = cfg_data[bbr_pkg::HCFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= bbr_pkg::WIDTH_LAST_RST;
			h_last_q <= bbr_pkg::HEIGHT_LAST_RST;
		end else if (cfg_we) begin
			unique case (bbr_pkg::reg_index_t'(cfg_index))
				bbr_pkg::REG_FRAME_WIDTH: begin
					if (cfg_w < bbr_pkg::WCFG_W'(3))
						w_last_q <= CW'(2);
					else if (cfg_w > bbr_pkg::WCFG_W'(bbr_pkg::MAX_WIDTH))
						w_last_q <= CW'(bbr_pkg::MAX_WIDTH - 1);
					else
						w_last_q <= CW'(cfg_w - bbr_pkg::WCFG_W'(1));
				end
				bbr_pkg::REG_FRAME_HEIGHT: begin
					if (cfg_h < bbr_pkg::HCFG_W'(3))
						h_last_q <= RW'(2);
					else if (cfg_h > bbr_pkg::HCFG_W'(bbr_pkg::MAX_HEIGHT))
						h_last_q <= RW'(bbr_pkg::MAX_HEIGHT - 1);
					else
						h_last_q <= RW'(cfg_h - bbr_pkg::HCFG_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

	// stage valids and handshakes
	logic s1_valid_q, s2_valid_q;
	logic int_pend_q, bor_pend_q;
	logic s1_adv, s2_adv, s2_load, s3_free, accept, out_fire;

	// position of the incoming pixel
	logic [RW-1:0] row_q, r0, pos_r;
	logic [CW-1:0] col_q, c0, pos_c;
	logic [RW:0]   r1;
	logic          in_int, in_bor;

	always_comb begin
		r0 = s_axis_tuser ? '0 : row_q;
		c0 = s_axis_tuser ? '0 : col_q;
		if (c0 > w_last_q) begin
			pos_c = '0;
			r1    = {1'b0, r0} + (RW+1)'(1);
		end else begin
			pos_c = c0;
			r1    = {1'b0, r0};
		end
		pos_r  = (r1 > {1'b0, h_last_q}) ? '0 : r1[RW-1:0];
		in_int = (pos_r >= RW'(2)) && (pos_c >= CW'(2));
		in_bor = (pos_r == '0) || (pos_r == h_last_q) || (pos_c == '0) || (pos_c == w_last_q);
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (pos_c == w_last_q) begin
				col_q <= '0;
				row_q <= (pos_r == h_last_q) ? '0 : pos_r + RW'(1);
			end else begin
				col_q <= pos_c + CW'(1);
				row_q <= pos_r;
			end
		end
	end

	// stage 1: line buffer data arrives, window sums
	logic [RW-1:0]          r_s1;
	logic [CW-1:0]          c_s1;
	bbr_pkg::pixel_t        px_s1, fwd_up2_s1, fwd_up1_s1;
	logic                   fwd_s1, int_s1, bor_s1;
	bbr_pkg::pixel_t        older_rd, newer_rd, up2, up1;
	bbr_pkg::pixel_t        win_q [6];
	logic [2:0][SW-1:0]     sum;

	assign up2 = fwd_s1 ? fwd_up2_s1 : older_rd;
	assign up1 = fwd_s1 ? fwd_up1_s1 : newer_rd;

	bbr_ram #(.WIDTH(bbr_pkg::PIX_W), .DEPTH(bbr_pkg::MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (s1_valid_q && s1_adv),
		.waddr (c_s1[bbr_pkg::ADDR_W-1:0]),
		.wdata (up1),
		.re    (accept),
		.raddr (pos_c[bbr_pkg::ADDR_W-1:0]),
		.rdata (older_rd)
	);

	bbr_ram #(.WIDTH(bbr_pkg::PIX_W), .DEPTH(bbr_pkg::MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (s1_valid_q && s1_adv),
		.waddr (c_s1[bbr_pkg::ADDR_W-1:0]),
		.wdata (px_s1),
		.re    (accept),
		.raddr (pos_c[bbr_pkg::ADDR_W-1:0]),
		.rdata (newer_rd)
	);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = SW'(win_q[0][ch*8 +: 8]) + SW'(win_q[1][ch*8 +: 8])
				+ SW'(win_q[2][ch*8 +: 8]) + SW'(win_q[3][ch*8 +: 8])
				+ SW'(win_q[4][ch*8 +: 8]) + SW'(win_q[5][ch*8 +: 8])
				+ SW'(up2[ch*8 +: 8]) + SW'(up1[ch*8 +: 8]) + SW'(px_s1[ch*8 +: 8]);
		end
	end

	// stage 2: divide by nine
	logic [RW-1:0]       r_s2;
	logic [CW-1:0]       c_s2;
	bbr_pkg::pixel_t     px_s2;
	logic                int_s2, bor_s2;
	logic [2:0][SW-1:0]  sum_s2;
	logic [2:0][SW+bbr_pkg::RECIP9_W-1:0] prod;
	bbr_pkg::pixel_t     avg;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = (SW+bbr_pkg::RECIP9_W)'(sum_s2[ch] + SW'(4))
				* (SW+bbr_pkg::RECIP9_W)'(bbr_pkg::RECIP9);
			avg[ch*8 +: 8] = prod[ch][bbr_pkg::RECIP_SH +: 8];
		end
	end

	// stage 3: output register, interior result before border result
	logic [RW-1:0]   int_r_s3, bor_r_s3;
	logic [CW-1:0]   int_c_s3, bor_c_s3;
	bbr_pkg::pixel_t int_px_s3, bor_px_s3;
	logic [RW-1:0]   o_r;
	logic [CW-1:0]   o_c;
	bbr_pkg::pixel_t o_px;

	assign m_axis_tvalid = int_pend_q || bor_pend_q;
	assign m_axis_tlast  = !(int_pend_q && bor_pend_q);
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign o_r           = int_pend_q ? int_r_s3 : bor_r_s3;
	assign o_c           = int_pend_q ? int_c_s3 : bor_c_s3;
	assign o_px          = int_pend_q ? int_px_s3 : bor_px_s3;
	assign m_axis_tdata  = {1'b0, o_px[7:0], o_px[15:8], o_px[23:16], o_c, o_r};

	assign s3_free       = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);
	assign s2_adv        = !s2_valid_q || !(int_s2 || bor_s2) || s3_free;
	// a pixel without results passes stage 2 and leaves the output register alone
	assign s2_load       = s2_valid_q && (int_s2 || bor_s2) && s3_free;
	assign s1_adv        = !s1_valid_q || s2_adv;
	assign s_axis_tready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			int_pend_q <= 1'b0;
			bor_pend_q <= 1'b0;
		end else begin
			if (s1_adv)
				s1_valid_q <= accept;
			if (s2_adv)
				s2_valid_q <= s1_valid_q;
			if (s2_load) begin
				int_pend_q <= int_s2;
				bor_pend_q <= bor_s2;
			end else if (out_fire) begin
				if (int_pend_q)
					int_pend_q <= 1'b0;
				else
					bor_pend_q <= 1'b0;
			end else if (s3_free) begin
				int_pend_q <= 1'b0;
				bor_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1   <= pos_r;
			c_s1   <= pos_c;
			px_s1  <= s_axis_tdata[7:0] << 16 | {8'd0, s_axis_tdata[15:8], 8'd0}
				| {16'd0, s_axis_tdata[23:16]};
			int_s1 <= in_int;
			bor_s1 <= in_bor;
			// the column written by the pixel leaving stage 1 right now
			fwd_s1     <= s1_valid_q && (c_s1 == pos_c);
			fwd_up2_s1 <= up1;
			fwd_up1_s1 <= px_s1;
		end
		if (s1_valid_q && s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up2;
			win_q[4] <= up1;
			win_q[5] <= px_s1;
			r_s2     <= r_s1;
			c_s2     <= c_s1;
			px_s2    <= px_s1;
			int_s2   <= int_s1;
			bor_s2   <= bor_s1;
			sum_s2   <= sum;
		end
		if (s2_load) begin
			int_r_s3  <= r_s2 - RW'(1);
			int_c_s3  <= c_s2 - CW'(1);
			int_px_s3 <= avg;
			bor_r_s3  <= r_s2;
			bor_c_s3  <= c_s2;
			bor_px_s3 <= px_s2;
		end
	end

endmodule

// ===== dv/box_blur_3x3_rgb_checker.sv =====
// predicts and checks the blurred pixel stream of box_blur_3x3_rgb
// depends on bbr_pkg; instantiated beside the block by box_blur_3x3_rgb_test
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [23:0]                    s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                           s_axis_tuser,  // frame_start
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [47:0]                    m_axis_tdata,  // out_row, out_col, red, green, blue, 0
	input  logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             results_due
);

	typedef struct packed {
		logic [bbr_pkg::ROW_W-1:0] row;
		logic [bbr_pkg::COL_W-1:0] col;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} blur_pixel_t;

	blur_pixel_t       due_pixels[$];
	bbr_pkg::pixel_t   line_far[bbr_pkg::MAX_WIDTH];   // row r-2
	bbr_pkg::pixel_t   line_near[bbr_pkg::MAX_WIDTH];  // row r-1
	bbr_pkg::pixel_t   taps[6];                        // columns c-2, c-1 of rows r-2..r
	int unsigned       next_row;
	int unsigned       next_col;
	logic [bbr_pkg::WCFG_W-1:0] cols_reg;
	logic [bbr_pkg::HCFG_W-1:0] rows_reg;
	int                error_total = 0;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic queue_pixel(int unsigned r, int unsigned c, bbr_pkg::pixel_t px, logic last);
		due_pixels.push_back('{bbr_pkg::ROW_W'(r), bbr_pkg::COL_W'(c), px[23:16], px[15:8],
			px[7:0], last});
	endtask

	// advance the raster position by one pixel and queue what it releases
	task automatic blur_pixel(bbr_pkg::pixel_t px, logic frame_start);
		int unsigned     w, h, r, c, sum;
		bbr_pkg::pixel_t up2, up1, avg;
		logic            interior, border;
		w = clamp_dim(cols_reg, bbr_pkg::MAX_WIDTH);
		h = clamp_dim(rows_reg, bbr_pkg::MAX_HEIGHT);
		if (frame_start) begin
			next_row = 0;
			next_col = 0;
		end
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h)
			next_row = 0;
		r = next_row;
		c = next_col;
		up2 = line_far[c];
		up1 = line_near[c];
		interior = (r >= 2) && (c >= 2);
		border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		if (interior) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum = up2[ch*8 +: 8] + up1[ch*8 +: 8] + px[ch*8 +: 8];
				for (int k = 0; k < 6; k++)
					sum += taps[k][ch*8 +: 8];
				avg[ch*8 +: 8] = 8'((sum + 4) / 9);
			end
			queue_pixel(r - 1, c - 1, avg, !border);
		end
		if (border)
			queue_pixel(r, c, px, 1'b1);
		taps[0] = taps[3];
		taps[1] = taps[4];
		taps[2] = taps[5];
		taps[3] = up2;
		taps[4] = up1;
		taps[5] = px;
		line_far[c] = up1;
		line_near[c] = px;
		next_col = c + 1;
		if (next_col >= w) begin
			next_col = 0;
			next_row = r + 1;
			if (next_row >= h)
				next_row = 0;
		end
	endtask

	always @(posedge clk) begin
		blur_pixel_t got, want;
		if (!arst_n) begin
			due_pixels.delete();
			for (int i = 0; i < bbr_pkg::MAX_WIDTH; i++) begin
				line_far[i] = '0;
				line_near[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				taps[i] = '0;
			next_row = 0;
			next_col = 0;
			cols_reg = 12'd640;
			rows_reg = 13'd480;
			results_due <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bbr_pkg::REG_FRAME_WIDTH)
					cols_reg = cfg_data[bbr_pkg::WCFG_W-1:0];
				else
					rows_reg = cfg_data[bbr_pkg::HCFG_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[11:0], m_axis_tdata[22:12], m_axis_tdata[30:23],
					m_axis_tdata[38:31], m_axis_tdata[46:39], m_axis_tlast};
				if (due_pixels.size() == 0) begin
					error_total++;
					if (error_total <= 10)
						$display("%t unexpected result row %0d col %0d rgb %h %h %h last %b",
							$realtime, got.row, got.col, got.red, got.green, got.blue, got.last);
				end else begin
					want = due_pixels.pop_front();
					if (got.row !== want.row || got.col !== want.col || got.red !== want.red ||
							got.green !== want.green || got.blue !== want.blue ||
							got.last !== want.last) begin
						error_total++;
						if (error_total <= 10)
							$display("%t mismatch: expected row %0d col %0d rgb %h %h %h last %b, %s",
								$realtime, want.row, want.col, want.red, want.green, want.blue,
								want.last, $sformatf("got row %0d col %0d rgb %h %h %h last %b",
								got.row, got.col, got.red, got.green, got.blue, got.last));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				blur_pixel({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]},
					s_axis_tuser);
			results_due <= due_pixels.size();
			mismatches <= error_total;
		end
	end

endmodule

// ===== dv/box_blur_3x3_rgb_test.sv =====
// stimulus and verdict for box_blur_3x3_rgb: directed frames, then random frames
// depends on bbr_pkg, box_blur_3x3_rgb and box_blur_3x3_rgb_checker
`timescale 1ns / 100ps

module box_blur_3x3_rgb_test;

	typedef enum int {
		READY_ALWAYS,
		READY_HALF,
		READY_MOST,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_EVERY    = 300;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [23:0]                    s_axis_tdata = '0;  // in_red, in_green, in_blue
	logic                           s_axis_tuser = 1'b0;  // frame_start
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [47:0]                    m_axis_tdata;  // out_row, out_col, red, green, blue, 0
	logic                           m_axis_tlast;
	logic                           cfg_we = 1'b0;
	bbr_pkg::reg_index_t            cfg_index = bbr_pkg::REG_FRAME_WIDTH;
	logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                             mismatch_count;
	int                             results_due;

	int          burst_left = 0;
	int unsigned cur_cols = 640;
	bit          must_restart = 1'b0;
	bit          quiet_sender = 1'b0;

	box_blur_3x3_rgb u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	box_blur_3x3_rgb_checker u_blur_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatch_count),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("box_blur_3x3_rgb verification failed");
		$finish;
	end

	// receiver: changing ready patterns, plus long hold-offs that back up the block
	initial begin
		ready_mode_t mode;
		int          mode_left;
		int          hold_left;
		int          results_seen;
		int          next_hold;
		mode = READY_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		results_seen = 0;
		next_hold = 150;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				results_seen++;
			// start a hold-off only while the sender is offering, so the input stalls
			if (hold_left == 0 && results_seen >= next_hold && s_axis_tvalid) begin
				hold_left = HOLD_CYCLES;
				next_hold = results_seen + HOLD_EVERY;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = ready_mode_t'($urandom_range(0, 4));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					READY_ALWAYS: m_axis_tready <= 1'b1;
					READY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
					READY_MOST:   m_axis_tready <= ($urandom_range(0, 7) != 0);
					READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default:      m_axis_tready <= (mode_left % 5 != 0);
				endcase
			end
		end
	end

	function automatic logic [23:0] random_rgb();
		logic [23:0] v;
		v = 24'($urandom);
		if ($urandom_range(0, 7) == 0)
			for (int k = 0; k < 3; k++)
				v[k*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return v;
	endfunction

	// one pixel transfer; bursts of random length with random gaps in between
	task automatic send_pixel(input logic [23:0] rgb, input logic frame_start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (quiet_sender)
				gap = 0;
			else if ($urandom_range(0, 5) == 0)
				gap = $urandom_range(8, 30);
			else
				gap = $urandom_range(0, 4);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rgb;
		s_axis_tuser <= frame_start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	// stop sending until every queued result has been taken, then let the pipe settle
	task automatic wait_idle();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a wider frame must restart at row 0 so no unwritten line buffer entry is read
	task automatic set_frame(input logic [bbr_pkg::CFG_DATA_W-1:0] cols,
			input logic [bbr_pkg::CFG_DATA_W-1:0] rows);
		int unsigned eff;
		cfg_we <= 1'b1;
		cfg_index <= bbr_pkg::REG_FRAME_WIDTH;
		cfg_data <= cols;
		@(posedge clk);
		cfg_index <= bbr_pkg::REG_FRAME_HEIGHT;
		cfg_data <= rows;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff = 32'(cols[bbr_pkg::WCFG_W-1:0]);
		if (eff < 3)
			eff = 3;
		else if (eff > bbr_pkg::MAX_WIDTH)
			eff = bbr_pkg::MAX_WIDTH;
		must_restart = (eff > cur_cols);
		cur_cols = eff;
	endtask

	task automatic run_phase(input logic [bbr_pkg::CFG_DATA_W-1:0] cols,
			input logic [bbr_pkg::CFG_DATA_W-1:0] rows, input int count, input bit noisy);
		logic frame_start;
		set_frame(cols, rows);
		for (int i = 0; i < count; i++) begin
			if (i == 0)
				frame_start = must_restart || ($urandom_range(0, 1) != 0);
			else
				frame_start = noisy && ($urandom_range(0, 29) == 0);
			send_pixel(random_rgb(), frame_start);
		end
		wait_idle();
	endtask

	initial begin
		int                             random_sent;
		int                             kind;
		int                             wf;
		int                             hf;
		int                             count;
		logic [bbr_pkg::CFG_DATA_W-1:0] cols;
		logic [bbr_pkg::CFG_DATA_W-1:0] rows;
		random_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturated frame, then a rounding frame that starts by wrapping past the end
		set_frame(13'd3, 13'd3);
		for (int i = 0; i < 9; i++)
			send_pixel(24'hffffff, i == 0);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 0) ? {8'd0, 8'd5, 8'd4} : {8'd255, 8'd0, 8'd0}, 1'b0);
		wait_idle();
		// stop mid-frame, then shrink so both counters wrap
		set_frame(13'd5, 13'd5);
		for (int i = 0; i < 14; i++)
			send_pixel(random_rgb(), i == 0);
		wait_idle();
		set_frame(13'd3, 13'd3);
		for (int i = 0; i < 5; i++)
			send_pixel(random_rgb(), 1'b0);
		wait_idle();

		// both registers under range, width upper data bit ignored
		run_phase(13'h1001, 13'd2, 20, 1'b0);
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			quiet_sender = ($urandom_range(0, 3) == 0);
			wf = $urandom_range(3, 12);
			hf = $urandom_range(3, 8);
			cols = bbr_pkg::CFG_DATA_W'(wf);
			rows = bbr_pkg::CFG_DATA_W'(hf);
			if ($urandom_range(0, 7) == 0)
				cols[12] = 1'b1;
			case (kind)
				0: begin
					wf = 3;
					cols = bbr_pkg::CFG_DATA_W'($urandom_range(0, 2));
					cols[12] = 1'($urandom_range(0, 1));
					rows = bbr_pkg::CFG_DATA_W'($urandom_range(0, 8));
					hf = (rows < bbr_pkg::CFG_DATA_W'(3)) ? 3 : int'(rows);
				end
				1: cols = bbr_pkg::CFG_DATA_W'($urandom_range(bbr_pkg::MAX_WIDTH + 1, 4095));
				2: rows = bbr_pkg::CFG_DATA_W'($urandom_range(bbr_pkg::MAX_HEIGHT + 1, 8191));
				default: ;
			endcase
			if (kind == 1 || kind == 2)
				count = $urandom_range(20, 60);
			else begin
				count = wf * hf * $urandom_range(1, 2);
				if ($urandom_range(0, 2) == 0)
					count += $urandom_range(1, wf * hf - 1);
			end
			run_phase(cols, rows, count, $urandom_range(0, 3) == 0);
			random_sent += count;
		end
		quiet_sender = 1'b0;

		if (mismatch_count == 0 && results_due == 0)
			$display("box_blur_3x3_rgb verification clean");
		else
			$display("box_blur_3x3_rgb verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bbr_pkg.sv
hdl/bbr_ram.sv
hdl/box_blur_3x3_rgb.sv
dv/box_blur_3x3_rgb_checker.sv
dv/box_blur_3x3_rgb_test.sv
